### src/chs_pkg.sv
// Package for the chained hash set: sizes, pointer widths and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package chs_pkg;

    // Table sizes; BUCKETS must be a power of two (bucket = low key bits)
    localparam int BUCKETS   = 1024;
    localparam int NODES     = 4096;
    localparam int KEY_WIDTH = 32;

    // Field widths of the ports
    localparam int IN_KEY_W  = 32;

    // Derived widths
    localparam int BUCKET_W  = $clog2(BUCKETS);
    localparam int NODE_W    = $clog2(NODES);
    // Chain pointer: 0 is end of chain, n names node n-1
    localparam int PTR_W     = $clog2(NODES + 1);

    // Opcode values
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;    // write zero to one bucket head, advance sweep
        logic load;        // accept item, read bucket head
        logic ins_commit;  // store node, link at head, bump pool count
        logic walk_start;  // read node named by bucket head
        logic walk_next;   // read node named by current link
        logic res_valid;   // register a result
        logic res_found;
        logic res_full;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;    // sweep at last bucket
        logic is_query;    // latched opcode is a query
        logic pool_full;   // every node taken
        logic head_null;   // bucket head ends the chain
        logic link_null;   // node link ends the chain
        logic key_match;   // node key equals item key
    } t_status;

endpackage

### src/chs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/chs_dp.sv
// Datapath of the chained hash set: bucket head and node memories,
// pool count, clear sweep counter and result registers. Uses chs_pkg, chs_ram.
`timescale 1ns / 1ps

module chs_dp import chs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_opcode,
    input  logic [IN_KEY_W-1:0] i_key,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic                o_done,
    output logic                o_found,
    output logic                o_full_res
);

    logic [KEY_WIDTH-1:0] r_key;
    logic                 r_is_query;
    logic [PTR_W-1:0]     r_used;
    logic [BUCKET_W-1:0]  r_clr_cnt;
    logic                 r_done;
    logic                 r_found;
    logic                 r_full;

    logic [PTR_W-1:0]     head_q;
    logic [PTR_W-1:0]     link_q;
    logic [KEY_WIDTH-1:0] key_q;

    logic                 bkt_wr_en;
    logic [BUCKET_W-1:0]  bkt_wr_addr;
    logic [PTR_W-1:0]     bkt_wr_data;
    logic                 node_rd_en;
    logic [NODE_W-1:0]    node_rd_addr;
    logic [PTR_W-1:0]     used_inc;

    assign used_inc = r_used + PTR_W'(1);

    // Item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key      <= i_key[KEY_WIDTH-1:0];
            r_is_query <= (i_opcode == OP_QUERY);
        end
    end

    // Pool count and clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.ins_commit) begin
                r_used <= used_inc;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + BUCKET_W'(1);
            end
        end
    end

    // Bucket head memory: cleared by the sweep, updated by inserts
    assign bkt_wr_en   = i_cmd.clr_step | i_cmd.ins_commit;
    assign bkt_wr_addr = i_cmd.clr_step ? r_clr_cnt : r_key[BUCKET_W-1:0];
    assign bkt_wr_data = i_cmd.clr_step ? '0 : used_inc;

    chs_ram #(
        .WIDTH (PTR_W),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bkt_wr_en),
        .i_wr_addr (bkt_wr_addr),
        .i_wr_data (bkt_wr_data),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr (i_key[BUCKET_W-1:0]),
        .o_rd_data (head_q)
    );

    // Node read address: pointer minus one, from head or from link
    assign node_rd_en   = i_cmd.walk_start | i_cmd.walk_next;
    assign node_rd_addr = i_cmd.walk_start ? NODE_W'(head_q - PTR_W'(1))
                                           : NODE_W'(link_q - PTR_W'(1));

    // Node key and link memories share the address
    chs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (NODES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.ins_commit),
        .i_wr_addr (r_used[NODE_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (node_rd_en),
        .i_rd_addr (node_rd_addr),
        .o_rd_data (key_q)
    );

    chs_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NODES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.ins_commit),
        .i_wr_addr (r_used[NODE_W-1:0]),
        .i_wr_data (head_q),
        .i_rd_en   (node_rd_en),
        .i_rd_addr (node_rd_addr),
        .o_rd_data (link_q)
    );

    // Status to controller
    always_comb begin
        o_status.clr_last  = (r_clr_cnt == BUCKET_W'(BUCKETS - 1));
        o_status.is_query  = r_is_query;
        o_status.pool_full = (r_used == PTR_W'(NODES));
        o_status.head_null = (head_q == '0) || (head_q > r_used);
        o_status.link_null = (link_q == '0) || (link_q > r_used);
        o_status.key_match = (key_q == r_key);
    end

    // Result registers: strobe lasts one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_valid) begin
            r_found <= i_cmd.res_found;
            r_full  <= i_cmd.res_full;
        end
    end

    assign o_done     = r_done;
    assign o_found    = r_found;
    assign o_full_res = r_full;

`ifndef SYNTH
    // Pool count never passes the pool size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= PTR_W'(NODES))
        else $error("node pool count beyond pool size");

    // Each committed insert takes exactly one node
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_commit |=> r_used == $past(used_inc))
        else $error("pool count did not advance on insert");

    // An insert is never committed into a full pool
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_commit |-> !o_status.pool_full)
        else $error("insert committed with pool full");
`endif

endmodule

### src/chs_ctrl.sv
// Controller of the chained hash set: clear sweep, item accept, insert
// commit and chain walk sequencing. Uses chs_pkg.
`timescale 1ns / 1ps

module chs_ctrl import chs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_HEAD  = 2'd2;
    localparam logic [1:0] S_NODE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HEAD;
                end
            end
            S_HEAD: begin
                if (!i_status.is_query) begin
                    o_cmd.res_valid = 1'b1;
                    if (i_status.pool_full) begin
                        o_cmd.res_full = 1'b1;
                    end else begin
                        o_cmd.ins_commit = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (i_status.head_null) begin
                    o_cmd.res_valid = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_NODE;
                end
            end
            S_NODE: begin
                if (i_status.key_match) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_found = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_status.link_null) begin
                    o_cmd.res_valid = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.walk_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the bucket clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTH
    // An accepted transfer always moves on to the head lookup
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_state == S_HEAD)
        else $error("accepted item did not start head lookup");

    // After a result the controller is free again
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_valid |=> r_state == S_IDLE)
        else $error("controller busy after result");

    // Insert results only come from the head step
    a_ins_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.res_valid && !i_status.is_query) |-> r_state == S_HEAD)
        else $error("insert result outside head step");
`endif

endmodule

### src/chained_hash_set_top.sv
// Chained hash set. An insert reads the bucket head and then commits; a query
// reads the bucket head and then walks the chain with one registered
// node-memory read per node visited. The next item is accepted in the cycle the
// result strobe shows. The result cannot stall.
// Reset (synchronous, active low) runs a sweep zeroing each bucket head in
// turn; busy stays high until it ends.
`timescale 1ns / 1ps

module chained_hash_set_top import chs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [IN_KEY_W-1:0] i_key,
    output logic                o_done,
    output logic                o_found,
    output logic                o_full_res
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    chs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Memories and result registers
    chs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_opcode   (i_opcode),
        .i_key      (i_key),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_done     (o_done),
        .o_found    (o_found),
        .o_full_res (o_full_res)
    );

endmodule
